FILE: rtl/btp_pkg.sv
// btp_pkg: shared types, register codes and reset values for the
// battery temperature protection block. No dependencies.
`default_nettype none

package btp_pkg;

   localparam int TEMP_W                 = 16;
   localparam int COUNT_W                = 8;
   localparam int CSR_INDEX_W            = 4;
   localparam int NUM_SLOTS              = 4;
   localparam int DEBOUNCE_TICKS_DEFAULT = 100;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CFG_CHARGE_HOT_TRIP     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_CHARGE_HOT_RELEASE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CFG_CHARGE_COLD_TRIP    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CFG_CHARGE_COLD_RELEASE = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CFG_DRAIN_HOT_TRIP      = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CFG_DRAIN_HOT_RELEASE   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CFG_DRAIN_COLD_TRIP     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CFG_DRAIN_COLD_RELEASE  = 4'd7;

   // threshold reset values
   localparam logic [TEMP_W-1:0] RST_CHARGE_HOT_TRIP     = 16'd3181;
   localparam logic [TEMP_W-1:0] RST_CHARGE_HOT_RELEASE  = 16'd3131;
   localparam logic [TEMP_W-1:0] RST_CHARGE_COLD_TRIP    = 16'd2731;
   localparam logic [TEMP_W-1:0] RST_CHARGE_COLD_RELEASE = 16'd2781;
   localparam logic [TEMP_W-1:0] RST_DRAIN_HOT_TRIP      = 16'd3331;
   localparam logic [TEMP_W-1:0] RST_DRAIN_HOT_RELEASE   = 16'd3281;
   localparam logic [TEMP_W-1:0] RST_DRAIN_COLD_TRIP     = 16'd2531;
   localparam logic [TEMP_W-1:0] RST_DRAIN_COLD_RELEASE  = 16'd2581;

   // slot order of counters and flags
   localparam int SLOT_CHARGE_HOT  = 0;
   localparam int SLOT_CHARGE_COLD = 1;
   localparam int SLOT_DRAIN_HOT   = 2;
   localparam int SLOT_DRAIN_COLD  = 3;

   typedef struct packed {
      logic [TEMP_W-1:0] charge_hot_trip;
      logic [TEMP_W-1:0] charge_hot_release;
      logic [TEMP_W-1:0] charge_cold_trip;
      logic [TEMP_W-1:0] charge_cold_release;
      logic [TEMP_W-1:0] drain_hot_trip;
      logic [TEMP_W-1:0] drain_hot_release;
      logic [TEMP_W-1:0] drain_cold_trip;
      logic [TEMP_W-1:0] drain_cold_release;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_a;
      logic [TEMP_W-1:0] temp_b;
      logic [TEMP_W-1:0] temp_c;
      logic              is_charging;
      logic              scan_enable;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               fault;
   } slot_state_type;

endpackage

`default_nettype wire

FILE: rtl/btp_ifs.sv
// btp_ifs: valid/ready channel interfaces for request, response and csr
// writes. Depends on btp_pkg.
`default_nettype none

interface btp_req_if
   import btp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temp_a;
   logic [TEMP_W-1:0] temp_b;
   logic [TEMP_W-1:0] temp_c;
   logic              is_charging;
   logic              scan_enable;

   modport source (output valid, temp_a, temp_b, temp_c, is_charging, scan_enable,
                   input ready);
   modport sink   (input valid, temp_a, temp_b, temp_c, is_charging, scan_enable,
                   output ready);
endinterface

interface btp_rsp_if;
   logic valid;
   logic ready;
   logic charge_hot_fault;
   logic charge_cold_fault;
   logic drain_hot_fault;
   logic drain_cold_fault;

   modport source (output valid, charge_hot_fault, charge_cold_fault,
                   drain_hot_fault, drain_cold_fault, input ready);
   modport sink   (input valid, charge_hot_fault, charge_cold_fault,
                   drain_hot_fault, drain_cold_fault, output ready);
endinterface

interface btp_csr_if
   import btp_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [TEMP_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/btp_csr.sv
// btp_csr: threshold register file, written through the csr channel.
// Depends on btp_pkg and btp_ifs.
`default_nettype none

module btp_csr
   import btp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   btp_csr_if.sink    csr_bus,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CFG_CHARGE_HOT_TRIP:     cfg_in.charge_hot_trip     = csr_bus.data;
            CFG_CHARGE_HOT_RELEASE:  cfg_in.charge_hot_release  = csr_bus.data;
            CFG_CHARGE_COLD_TRIP:    cfg_in.charge_cold_trip    = csr_bus.data;
            CFG_CHARGE_COLD_RELEASE: cfg_in.charge_cold_release = csr_bus.data;
            CFG_DRAIN_HOT_TRIP:      cfg_in.drain_hot_trip      = csr_bus.data;
            CFG_DRAIN_HOT_RELEASE:   cfg_in.drain_hot_release   = csr_bus.data;
            CFG_DRAIN_COLD_TRIP:     cfg_in.drain_cold_trip     = csr_bus.data;
            CFG_DRAIN_COLD_RELEASE:  cfg_in.drain_cold_release  = csr_bus.data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_hot_trip     <= RST_CHARGE_HOT_TRIP;
         cfg_ff.charge_hot_release  <= RST_CHARGE_HOT_RELEASE;
         cfg_ff.charge_cold_trip    <= RST_CHARGE_COLD_TRIP;
         cfg_ff.charge_cold_release <= RST_CHARGE_COLD_RELEASE;
         cfg_ff.drain_hot_trip      <= RST_DRAIN_HOT_TRIP;
         cfg_ff.drain_hot_release   <= RST_DRAIN_HOT_RELEASE;
         cfg_ff.drain_cold_trip     <= RST_DRAIN_COLD_TRIP;
         cfg_ff.drain_cold_release  <= RST_DRAIN_COLD_RELEASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/btp_slot.sv
// btp_slot: next-state logic of one debounced temperature check (hot or
// cold). Depends on btp_pkg.
`default_nettype none

module btp_slot
   import btp_pkg::*;
#(
   parameter bit IS_COLD        = 1'b0,
   parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEFAULT
) (
   input  wire logic [TEMP_W-1:0] temp_a,
   input  wire logic [TEMP_W-1:0] temp_b,
   input  wire logic [TEMP_W-1:0] temp_c,
   input  wire logic [TEMP_W-1:0] trip,
   input  wire logic [TEMP_W-1:0] release_level,
   input  wire slot_state_type    cur,
   output slot_state_type         nxt
);

   localparam logic [COUNT_W-1:0] TICKS     = COUNT_W'(DEBOUNCE_TICKS);
   localparam logic [COUNT_W-1:0] TICKS_MAX = COUNT_W'(DEBOUNCE_TICKS + 1);

   logic               past_trip;
   logic               all_released;
   logic [COUNT_W-1:0] base_count;
   logic               fault_mid;

   // threshold compares, direction set by the check kind
   always_comb begin
      if (IS_COLD) begin
         past_trip    = (temp_a < trip) || (temp_b < trip) || (temp_c < trip);
         all_released = (temp_a > release_level) && (temp_b > release_level) &&
                        (temp_c > release_level);
      end else begin
         past_trip    = (temp_a > trip) || (temp_b > trip) || (temp_c > trip);
         all_released = (temp_a < release_level) && (temp_b < release_level) &&
                        (temp_c < release_level);
      end
   end

   // debounce count, first sensor not ready restarts a cold count
   always_comb begin
      base_count = cur.count;
      if (IS_COLD && (temp_a == '0)) begin
         base_count = '0;
      end
      fault_mid = cur.fault;
      nxt.count = '0;
      if (past_trip) begin
         if (base_count > TICKS) begin
            fault_mid = 1'b1;
         end
         if (base_count < TICKS_MAX) begin
            nxt.count = base_count + COUNT_W'(1);
         end else begin
            nxt.count = base_count;
         end
      end
      // hysteresis release
      nxt.fault = fault_mid && !all_released;
   end

endmodule

`default_nettype wire

FILE: rtl/battery_temperature_protection.sv
// battery_temperature_protection: top level, input register, four
// debounced checks and result register. Depends on btp_pkg, btp_ifs,
// btp_csr and btp_slot.
// A transaction accepted into the input register moves on into the result
// register and shows on rsp; while the result register is stalled it waits in the input register.
// Throughput: one transaction per cycle while rsp is not stalled, set by the
// single state update done when the input register moves into the result register.
// Reset: counters and fault flags clear, thresholds return to defaults.
`default_nettype none

module battery_temperature_protection
   import btp_pkg::*;
#(
   parameter int DEBOUNCE_TICKS = DEBOUNCE_TICKS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   btp_req_if.sink   req_bus,
   btp_rsp_if.source rsp_bus,
   btp_csr_if.sink   csr_bus
);

   cfg_type cfg;

   logic     in_valid_ff, in_valid_in;
   item_type in_item_ff, in_item_in;
   logic     out_valid_ff, out_valid_in;
   logic [NUM_SLOTS-1:0] out_flags_ff, out_flags_in;

   slot_state_type state_ff [NUM_SLOTS];
   slot_state_type state_in [NUM_SLOTS];
   slot_state_type slot_nxt [NUM_SLOTS];

   logic advance;
   logic req_take;

   btp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // handshake: input register drains whenever the result register frees
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_item_in.temp_a      = req_bus.temp_a;
         in_item_in.temp_b      = req_bus.temp_b;
         in_item_in.temp_c      = req_bus.temp_c;
         in_item_in.is_charging = req_bus.is_charging;
         in_item_in.scan_enable = req_bus.scan_enable;
      end
   end

   // per-slot check logic
   btp_slot #(.IS_COLD(1'b0), .DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_charge_hot (
      .temp_a        (in_item_ff.temp_a),
      .temp_b        (in_item_ff.temp_b),
      .temp_c        (in_item_ff.temp_c),
      .trip          (cfg.charge_hot_trip),
      .release_level (cfg.charge_hot_release),
      .cur           (state_ff[SLOT_CHARGE_HOT]),
      .nxt           (slot_nxt[SLOT_CHARGE_HOT])
   );

   btp_slot #(.IS_COLD(1'b1), .DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_charge_cold (
      .temp_a        (in_item_ff.temp_a),
      .temp_b        (in_item_ff.temp_b),
      .temp_c        (in_item_ff.temp_c),
      .trip          (cfg.charge_cold_trip),
      .release_level (cfg.charge_cold_release),
      .cur           (state_ff[SLOT_CHARGE_COLD]),
      .nxt           (slot_nxt[SLOT_CHARGE_COLD])
   );

   btp_slot #(.IS_COLD(1'b0), .DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_drain_hot (
      .temp_a        (in_item_ff.temp_a),
      .temp_b        (in_item_ff.temp_b),
      .temp_c        (in_item_ff.temp_c),
      .trip          (cfg.drain_hot_trip),
      .release_level (cfg.drain_hot_release),
      .cur           (state_ff[SLOT_DRAIN_HOT]),
      .nxt           (slot_nxt[SLOT_DRAIN_HOT])
   );

   btp_slot #(.IS_COLD(1'b1), .DEBOUNCE_TICKS(DEBOUNCE_TICKS)) u_drain_cold (
      .temp_a        (in_item_ff.temp_a),
      .temp_b        (in_item_ff.temp_b),
      .temp_c        (in_item_ff.temp_c),
      .trip          (cfg.drain_cold_trip),
      .release_level (cfg.drain_cold_release),
      .cur           (state_ff[SLOT_DRAIN_COLD]),
      .nxt           (slot_nxt[SLOT_DRAIN_COLD])
   );

   // state update on an advancing, scan-enabled item: active mode takes the check
   // result, the other mode drops its flags and keeps its counters
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         state_in[i] = state_ff[i];
         if (advance && in_item_ff.scan_enable) begin
            if ((i < SLOT_DRAIN_HOT) == in_item_ff.is_charging) begin
               state_in[i] = slot_nxt[i];
            end else begin
               state_in[i].fault = 1'b0;
            end
         end
         out_flags_in[i] = state_in[i].fault;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            state_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            state_ff[i] <= state_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      if (advance) begin
         out_flags_ff <= out_flags_in;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.charge_hot_fault  = out_flags_ff[SLOT_CHARGE_HOT];
   assign rsp_bus.charge_cold_fault = out_flags_ff[SLOT_CHARGE_COLD];
   assign rsp_bus.drain_hot_fault   = out_flags_ff[SLOT_DRAIN_HOT];
   assign rsp_bus.drain_cold_fault  = out_flags_ff[SLOT_DRAIN_COLD];

   // charge and drain faults never stand together
   a_mode_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((state_ff[SLOT_CHARGE_HOT].fault || state_ff[SLOT_CHARGE_COLD].fault) &&
        (state_ff[SLOT_DRAIN_HOT].fault || state_ff[SLOT_DRAIN_COLD].fault)))
      else $error("charge and drain faults set together");

   // a disabled scan leaves all counters and flags untouched
   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_item_ff.scan_enable) |=>
         ($stable(state_ff[0]) && $stable(state_ff[1]) &&
          $stable(state_ff[2]) && $stable(state_ff[3])))
      else $error("state changed on a disabled scan");

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_chk
      // counter saturates at one past the debounce limit
      a_count_sat: assert property (@(posedge clock) disable iff (reset)
         state_ff[g].count <= COUNT_W'(DEBOUNCE_TICKS + 1))
         else $error("debounce counter beyond saturation");

      // a fault only sets once the old count is past the limit
      a_set_after_debounce: assert property (@(posedge clock) disable iff (reset)
         $rose(state_ff[g].fault) |-> ($past(state_ff[g].count) >
                                       COUNT_W'(DEBOUNCE_TICKS)))
         else $error("fault set before debounce completed");
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for battery_temperature_protection, with a transaction-level
// fault flag predictor, random debounce episodes and threshold reprogramming between phases.
// Depends on btp_pkg, btp_ifs and the block's rtl.

module testbench;
   import btp_pkg::*;

   localparam int DEBOUNCE    = DEBOUNCE_TICKS_DEFAULT;
   localparam int NUM_REGS    = int'(CFG_DRAIN_COLD_RELEASE) + 1;
   localparam int CSR_DEPTH   = 1 << CSR_INDEX_W;
   localparam int TEMP_MAX    = (1 << TEMP_W) - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 100;

   typedef logic [NUM_SLOTS-1:0] flags_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [TEMP_W-1:0]      data;
   } csr_write_type;

   typedef enum int {EP_HOT, EP_COLD, EP_CALM, EP_NOISE} episode_type;
   typedef enum int {SET_DEFAULTS, SET_SHIFTED, SET_ALWAYS_TRIP, SET_NEVER_TRIP,
                     SET_RANDOM} setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   btp_req_if req_if();
   btp_rsp_if rsp_if();
   btp_csr_if csr_if();

   battery_temperature_protection #(
      .DEBOUNCE_TICKS(DEBOUNCE)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // predictor state: thresholds, debounce counters and fault flags
   logic [TEMP_W-1:0]  thresh [CSR_DEPTH];
   logic [COUNT_W-1:0] tick_count [NUM_SLOTS];
   flags_type          fault_state;

   item_type      pending_ticks [$];
   csr_write_type pending_writes [$];
   flags_type     expected_faults [$];

   string flag_names [NUM_SLOTS] = '{"charge_hot_fault", "charge_cold_fault",
                                     "drain_hot_fault", "drain_cold_fault"};

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int mismatches    = 0;
   int rsp_count     = 0;
   int cycles        = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // known values on every input from time zero
   initial begin
      req_if.valid       = 1'b0;
      req_if.temp_a      = '0;
      req_if.temp_b      = '0;
      req_if.temp_c      = '0;
      req_if.is_charging = 1'b0;
      req_if.scan_enable = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      thresh[CFG_CHARGE_HOT_TRIP]     = RST_CHARGE_HOT_TRIP;
      thresh[CFG_CHARGE_HOT_RELEASE]  = RST_CHARGE_HOT_RELEASE;
      thresh[CFG_CHARGE_COLD_TRIP]    = RST_CHARGE_COLD_TRIP;
      thresh[CFG_CHARGE_COLD_RELEASE] = RST_CHARGE_COLD_RELEASE;
      thresh[CFG_DRAIN_HOT_TRIP]      = RST_DRAIN_HOT_TRIP;
      thresh[CFG_DRAIN_HOT_RELEASE]   = RST_DRAIN_HOT_RELEASE;
      thresh[CFG_DRAIN_COLD_TRIP]     = RST_DRAIN_COLD_TRIP;
      thresh[CFG_DRAIN_COLD_RELEASE]  = RST_DRAIN_COLD_RELEASE;
      for (int s = 0; s < NUM_SLOTS; s++) tick_count[s] = '0;
      fault_state = '0;
   end

   task automatic report_error(input string msg);
      mismatches++;
      // keep the log readable when the block is badly broken
      if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
   endtask

   // debounce step: compare the old count, then count up to saturation
   function automatic void bump_count(int slot);
      if (tick_count[slot] > DEBOUNCE) fault_state[slot] = 1'b1;
      if (tick_count[slot] < DEBOUNCE + 1) tick_count[slot] = tick_count[slot] + 1'b1;
   endfunction

   function automatic void check_overheat(int slot, item_type it,
                                          logic [TEMP_W-1:0] trip, logic [TEMP_W-1:0] rel);
      if (it.temp_a > trip || it.temp_b > trip || it.temp_c > trip) bump_count(slot);
      else tick_count[slot] = '0;
      if (fault_state[slot] && it.temp_a < rel && it.temp_b < rel && it.temp_c < rel)
         fault_state[slot] = 1'b0;
   endfunction

   function automatic void check_undercool(int slot, item_type it,
                                           logic [TEMP_W-1:0] trip, logic [TEMP_W-1:0] rel);
      if (it.temp_a < trip || it.temp_b < trip || it.temp_c < trip) begin
         // first sensor not measured yet restarts the count
         if (it.temp_a == '0) tick_count[slot] = '0;
         bump_count(slot);
      end else begin
         tick_count[slot] = '0;
      end
      if (fault_state[slot] && it.temp_a > rel && it.temp_b > rel && it.temp_c > rel)
         fault_state[slot] = 1'b0;
   endfunction

   // one tick of the protection logic, returns the flags after the update
   function automatic flags_type predict_faults(item_type it);
      if (it.scan_enable) begin
         if (it.is_charging) begin
            fault_state[SLOT_DRAIN_HOT]  = 1'b0;
            fault_state[SLOT_DRAIN_COLD] = 1'b0;
            check_overheat(SLOT_CHARGE_HOT, it, thresh[CFG_CHARGE_HOT_TRIP],
                           thresh[CFG_CHARGE_HOT_RELEASE]);
            check_undercool(SLOT_CHARGE_COLD, it, thresh[CFG_CHARGE_COLD_TRIP],
                            thresh[CFG_CHARGE_COLD_RELEASE]);
         end else begin
            fault_state[SLOT_CHARGE_HOT]  = 1'b0;
            fault_state[SLOT_CHARGE_COLD] = 1'b0;
            check_overheat(SLOT_DRAIN_HOT, it, thresh[CFG_DRAIN_HOT_TRIP],
                           thresh[CFG_DRAIN_HOT_RELEASE]);
            check_undercool(SLOT_DRAIN_COLD, it, thresh[CFG_DRAIN_COLD_TRIP],
                            thresh[CFG_DRAIN_COLD_RELEASE]);
         end
      end
      return fault_state;
   endfunction

   // request driver
   always @(posedge clock) begin
      item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            nxt.temp_a      = req_if.temp_a;
            nxt.temp_b      = req_if.temp_b;
            nxt.temp_c      = req_if.temp_c;
            nxt.is_charging = req_if.is_charging;
            nxt.scan_enable = req_if.scan_enable;
            expected_faults.push_back(predict_faults(nxt));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_ticks.pop_front();
               req_if.temp_a      <= nxt.temp_a;
               req_if.temp_b      <= nxt.temp_b;
               req_if.temp_c      <= nxt.temp_c;
               req_if.is_charging <= nxt.is_charging;
               req_if.scan_enable <= nxt.scan_enable;
               req_if.valid       <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // threshold write driver, predictor copy updated on each accepted write to a mapped index
   always @(posedge clock) begin
      csr_write_type w;
      if (reset) begin
         csr_if.valid <= 1'b0;
      end else begin
         if (csr_if.valid && csr_if.ready && csr_if.index <= CFG_DRAIN_COLD_RELEASE)
            thresh[csr_if.index] = csr_if.data;
         if (!csr_if.valid || csr_if.ready) begin
            if (pending_writes.size() != 0) begin
               w = pending_writes.pop_front();
               csr_if.index <= w.index;
               csr_if.data  <= w.data;
               csr_if.valid <= 1'b1;
            end else begin
               csr_if.valid <= 1'b0;
            end
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      flags_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.drain_cold_fault, rsp_if.drain_hot_fault,
                rsp_if.charge_cold_fault, rsp_if.charge_hot_fault};
         if (expected_faults.size() == 0) begin
            report_error($sformatf("transaction %0d arrived with nothing expected", rsp_count));
         end else begin
            want = expected_faults.pop_front();
            for (int s = 0; s < NUM_SLOTS; s++)
               if (got[s] !== want[s])
                  report_error($sformatf("transaction %0d %s got %b expected %b",
                                         rsp_count, flag_names[s], got[s], want[s]));
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [TEMP_W-1:0] near(int base, int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > TEMP_MAX) v = TEMP_MAX;
      return v[TEMP_W-1:0];
   endfunction

   function automatic item_type pack_tick(int a, int b, int c, logic charging, logic scan);
      item_type it;
      it.temp_a      = a[TEMP_W-1:0];
      it.temp_b      = b[TEMP_W-1:0];
      it.temp_c      = c[TEMP_W-1:0];
      it.is_charging = charging;
      it.scan_enable = scan;
      return it;
   endfunction

   // one tick of an episode, temperatures placed around the current thresholds
   function automatic item_type make_tick(episode_type kind, logic charging);
      item_type          it;
      logic [TEMP_W-1:0] t [3];
      int hot_trip, hot_rel, cold_trip, cold_rel;
      hot_trip  = int'(charging ? thresh[CFG_CHARGE_HOT_TRIP]
                                : thresh[CFG_DRAIN_HOT_TRIP]);
      hot_rel   = int'(charging ? thresh[CFG_CHARGE_HOT_RELEASE]
                                : thresh[CFG_DRAIN_HOT_RELEASE]);
      cold_trip = int'(charging ? thresh[CFG_CHARGE_COLD_TRIP]
                                : thresh[CFG_DRAIN_COLD_TRIP]);
      cold_rel  = int'(charging ? thresh[CFG_CHARGE_COLD_RELEASE]
                                : thresh[CFG_DRAIN_COLD_RELEASE]);
      case (kind)
         EP_HOT: begin
            for (int k = 0; k < 3; k++) t[k] = near(hot_rel, 30);
            if ($urandom_range(0, 19) != 0) t[$urandom_range(0, 2)] = near(hot_trip + 25, 26);
         end
         EP_COLD: begin
            for (int k = 0; k < 3; k++) t[k] = near(cold_rel, 30);
            if ($urandom_range(0, 19) != 0) t[$urandom_range(0, 2)] = near(cold_trip - 25, 26);
            if ($urandom_range(0, 29) == 0) t[0] = '0;
         end
         EP_CALM: begin
            for (int k = 0; k < 3; k++)
               if (hot_rel - cold_rel > 2)
                  t[k] = TEMP_W'($urandom_range(cold_rel + 1, hot_rel - 1));
               else t[k] = near(cold_rel, 20);
            // land on or next to a release threshold now and then
            if ($urandom_range(0, 7) == 0)
               t[$urandom_range(0, 2)] = near($urandom_range(0, 1) ? hot_rel : cold_rel, 2);
         end
         default: begin
            for (int k = 0; k < 3; k++) t[k] = TEMP_W'($urandom);
         end
      endcase
      it.temp_a      = t[0];
      it.temp_b      = t[1];
      it.temp_c      = t[2];
      it.is_charging = ($urandom_range(0, 39) == 0) ? !charging : charging;
      it.scan_enable = ($urandom_range(0, 24) != 0);
      if (kind == EP_NOISE) begin
         it.is_charging = 1'($urandom_range(0, 1));
         it.scan_enable = 1'($urandom_range(0, 1));
      end
      return it;
   endfunction

   // random episodes: long excursions reach the debounce limit, short ones break it
   task automatic add_random_ticks(int n);
      int          added;
      int          len;
      int          pick;
      logic        charging;
      episode_type kind;
      added = 0;
      while (added < n) begin
         pick     = $urandom_range(0, 99);
         charging = 1'($urandom_range(0, 1));
         if (pick < 30) kind = EP_HOT;
         else if (pick < 60) kind = EP_COLD;
         else if (pick < 85) kind = EP_CALM;
         else kind = EP_NOISE;
         case (kind)
            EP_HOT, EP_COLD: len = ($urandom_range(0, 9) < 7) ? $urandom_range(100, 130)
                                                              : $urandom_range(1, 30);
            EP_CALM: len = $urandom_range(3, 40);
            default: len = $urandom_range(1, 12);
         endcase
         for (int k = 0; k < len && added < n; k++) begin
            pending_ticks.push_back(make_tick(kind, charging));
            added++;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || req_if.valid || expected_faults.size() != 0 ||
             pending_writes.size() != 0 || csr_if.valid)
         @(posedge clock);
   endtask

   function automatic logic [TEMP_W-1:0] shifted(logic [TEMP_W-1:0] base);
      return near(int'(base), 400);
   endfunction

   // program all eight thresholds, only while the block is idle
   task automatic apply_settings(setting_type kind);
      logic [TEMP_W-1:0] v [CSR_DEPTH];
      csr_write_type     w;
      case (kind)
         SET_SHIFTED: begin
            v[CFG_CHARGE_HOT_TRIP]     = shifted(RST_CHARGE_HOT_TRIP);
            v[CFG_CHARGE_HOT_RELEASE]  = shifted(RST_CHARGE_HOT_RELEASE);
            v[CFG_CHARGE_COLD_TRIP]    = shifted(RST_CHARGE_COLD_TRIP);
            v[CFG_CHARGE_COLD_RELEASE] = shifted(RST_CHARGE_COLD_RELEASE);
            v[CFG_DRAIN_HOT_TRIP]      = shifted(RST_DRAIN_HOT_TRIP);
            v[CFG_DRAIN_HOT_RELEASE]   = shifted(RST_DRAIN_HOT_RELEASE);
            v[CFG_DRAIN_COLD_TRIP]     = shifted(RST_DRAIN_COLD_TRIP);
            v[CFG_DRAIN_COLD_RELEASE]  = shifted(RST_DRAIN_COLD_RELEASE);
         end
         SET_ALWAYS_TRIP, SET_NEVER_TRIP: begin
            // extremes: trips at the rails, releases at the opposite rails
            v[CFG_CHARGE_HOT_TRIP]     = (kind == SET_ALWAYS_TRIP) ? '0 : '1;
            v[CFG_CHARGE_HOT_RELEASE]  = (kind == SET_ALWAYS_TRIP) ? '1 : '0;
            v[CFG_CHARGE_COLD_TRIP]    = (kind == SET_ALWAYS_TRIP) ? '1 : '0;
            v[CFG_CHARGE_COLD_RELEASE] = (kind == SET_ALWAYS_TRIP) ? '0 : '1;
            v[CFG_DRAIN_HOT_TRIP]      = v[CFG_CHARGE_HOT_TRIP];
            v[CFG_DRAIN_HOT_RELEASE]   = v[CFG_CHARGE_HOT_RELEASE];
            v[CFG_DRAIN_COLD_TRIP]     = v[CFG_CHARGE_COLD_TRIP];
            v[CFG_DRAIN_COLD_RELEASE]  = v[CFG_CHARGE_COLD_RELEASE];
         end
         SET_RANDOM: begin
            for (int r = 0; r < NUM_REGS; r++) v[r] = TEMP_W'($urandom);
         end
         default: begin
            v[CFG_CHARGE_HOT_TRIP]     = RST_CHARGE_HOT_TRIP;
            v[CFG_CHARGE_HOT_RELEASE]  = RST_CHARGE_HOT_RELEASE;
            v[CFG_CHARGE_COLD_TRIP]    = RST_CHARGE_COLD_TRIP;
            v[CFG_CHARGE_COLD_RELEASE] = RST_CHARGE_COLD_RELEASE;
            v[CFG_DRAIN_HOT_TRIP]      = RST_DRAIN_HOT_TRIP;
            v[CFG_DRAIN_HOT_RELEASE]   = RST_DRAIN_HOT_RELEASE;
            v[CFG_DRAIN_COLD_TRIP]     = RST_DRAIN_COLD_TRIP;
            v[CFG_DRAIN_COLD_RELEASE]  = RST_DRAIN_COLD_RELEASE;
         end
      endcase
      for (int r = 0; r < NUM_REGS; r++) begin
         w.index = r[CSR_INDEX_W-1:0];
         w.data  = v[r];
         pending_writes.push_back(w);
      end
      // write to an unmapped index, must be ignored
      if (kind == SET_RANDOM || $urandom_range(0, 1) == 0) begin
         w.index = CSR_INDEX_W'($urandom_range(int'(CFG_DRAIN_COLD_RELEASE) + 1,
                                               CSR_DEPTH - 1));
         w.data  = TEMP_W'($urandom);
         pending_writes.push_back(w);
      end
      wait_idle();
   endtask

   // directed ticks at the rails and around the reset thresholds
   task automatic add_directed_ticks();
      pending_ticks.push_back(pack_tick(0, 0, 0, 1'b1, 1'b0));
      pending_ticks.push_back(pack_tick(0, 0, 0, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(TEMP_MAX, TEMP_MAX, TEMP_MAX, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(TEMP_MAX, TEMP_MAX, TEMP_MAX, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(0, 0, 0, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(3181, 3181, 3181, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(3182, 3000, 3000, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(2730, 3000, 3000, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(2731, 2731, 2731, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(3000, 3332, 3000, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(3331, 3331, 3331, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(2600, 2600, 2530, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(0, 2600, 2600, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(3000, 0, 3000, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(3000, 3000, TEMP_MAX, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(TEMP_MAX, 0, TEMP_MAX, 1'b1, 1'b0));
      pending_ticks.push_back(pack_tick(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(16'h5555, 16'hAAAA, 0, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(3131, 3131, 3131, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(2781, 2781, 2781, 1'b1, 1'b1));
      pending_ticks.push_back(pack_tick(2581, 2581, 2581, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(3281, 3281, 3281, 1'b0, 1'b1));
      pending_ticks.push_back(pack_tick(2900, 2950, 3000, 1'b1, 1'b1));
   endtask

   // phase sequence
   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds, no idling
      send_idle_pct = 0;
      stall_pct     = 0;
      add_directed_ticks();
      add_random_ticks(250);
      wait_idle();

      // shifted thresholds, sender idling
      apply_settings(SET_SHIFTED);
      send_idle_pct = 45;
      stall_pct     = 0;
      add_random_ticks(350);
      wait_idle();

      // every scanned tick trips, receiver stalling
      apply_settings(SET_ALWAYS_TRIP);
      send_idle_pct = 0;
      stall_pct     = 45;
      add_random_ticks(200);
      wait_idle();

      // nothing can trip, both sides idling
      apply_settings(SET_NEVER_TRIP);
      send_idle_pct = 22;
      stall_pct     = 22;
      add_random_ticks(150);
      wait_idle();

      // arbitrary thresholds
      apply_settings(SET_RANDOM);
      add_random_ticks(300);
      wait_idle();

      // back to defaults, sender holds off mid phase until all results are in
      apply_settings(SET_DEFAULTS);
      send_idle_pct = 0;
      stall_pct     = 0;
      add_random_ticks(250);
      wait_idle();
      add_random_ticks(250);
      wait_idle();

      // let the pipeline settle and catch stray transactions
      repeat (8) @(posedge clock);
      if (expected_faults.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_faults.size()));
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/btp_pkg.sv
rtl/btp_ifs.sv
rtl/btp_csr.sv
rtl/btp_slot.sv
rtl/battery_temperature_protection.sv
tb/testbench.sv
